// ===== src/clmd_pkg.sv =====
package clmd_pkg;

    localparam int DEF_LENGTH_BITS = 24;
    localparam int MAX_LEN_W       = 24;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = '1;

    localparam logic [3:0] TAG_LEN  = 4'd15;
    localparam logic [3:0] TAG_LAST = 4'd14;
    localparam logic [2:0] TERM_LEN = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_SKIP   = 3'b100
    } clmd_phase_t;

    typedef enum logic [5:0] {
        VS_NONE   = 6'b000001,
        VS_LEAD   = 6'b000010,
        VS_SIGN   = 6'b000100,
        VS_DIGITS = 6'b001000,
        VS_TRAIL  = 6'b010000,
        VS_BAD    = 6'b100000
    } clmd_vstate_t;

    typedef enum logic [1:0] {
        KIND_BODY    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_MISSING = 2'd2,
        KIND_OVER    = 2'd3
    } clmd_kind_t;

    typedef struct packed {
        clmd_kind_t kind;
        logic [7:0] body_byte;
        logic       last;
    } clmd_result_t;

    // Text of the length tag, one character per position.
    function automatic logic [7:0] tag_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/clmd_input_stage.sv =====
module clmd_input_stage
    import clmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Take a new word whenever the held one is empty or being consumed.
    assign s_tready = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ===== src/clmd_core.sv =====
module clmd_core
    import clmd_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] cfg_wr_data,
    input  logic                 advance,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    output clmd_result_t         res
);

    localparam int AW = LENGTH_BITS + 1;
    localparam int PW = LENGTH_BITS + 4;
    localparam int CW = (AW > MAX_LEN_W) ? AW : MAX_LEN_W;

    logic [MAX_LEN_W-1:0]   max_len_reg;
    clmd_phase_t            phase_reg, phase_next;
    logic [3:0]             tag_idx_reg, tag_idx_next;
    logic [1:0]             term_cnt_reg, term_cnt_next;
    clmd_vstate_t           vs_reg, vs_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic                   seen_reg, seen_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    logic                   is_space, is_digit;
    logic [3:0]             digit;
    logic [AW-1:0]          acc_digit, acc_first;
    logic [PW-1:0]          prod, prod_first;
    logic [2:0]             term_new;
    logic [AW-1:0]          len_v;
    logic                   seen_v;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   restart;
    clmd_phase_t            load_phase;
    logic [LENGTH_BITS-1:0] load_rem;

    assign is_space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = 4'(in_byte - CH_ZERO);

    // acc * 10 + digit, saturating at 2^LENGTH_BITS
    assign prod = (PW'(acc_reg[LENGTH_BITS-1:0]) << 3) + (PW'(acc_reg[LENGTH_BITS-1:0]) << 1)
                + PW'(digit);
    assign prod_first = PW'(digit);
    always_comb begin
        if (acc_reg[LENGTH_BITS]) begin
            acc_digit = acc_reg;
        end else if (|prod[PW-1:LENGTH_BITS]) begin
            acc_digit = {1'b1, {LENGTH_BITS{1'b0}}};
        end else begin
            acc_digit = prod[AW-1:0];
        end
    end
    assign acc_first = prod_first[AW-1:0];

    // Terminator progress on CR LF CR LF
    always_comb begin
        if (term_cnt_reg == 2'd0 || term_cnt_reg == 2'd2) begin
            term_new = (in_byte == CH_CR) ? 3'(term_cnt_reg) + 3'd1 : 3'd0;
        end else if (in_byte == CH_LF) begin
            term_new = 3'(term_cnt_reg) + 3'd1;
        end else begin
            term_new = (in_byte == CH_CR) ? 3'd1 : 3'd0;
        end
    end

    assign rem_dec = rem_reg - LENGTH_BITS'(1);

    always_comb begin
        phase_next    = phase_reg;
        tag_idx_next  = tag_idx_reg;
        term_cnt_next = term_cnt_reg;
        vs_next       = vs_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        rem_next      = rem_reg;
        restart       = 1'b0;
        load_phase    = PH_HEADER;
        load_rem      = '0;
        res_valid     = 1'b0;
        res           = '0;
        len_v         = acc_reg;
        seen_v        = seen_reg;

        unique case (phase_reg)
            PH_BODY: begin
                res_valid     = 1'b1;
                res.kind      = KIND_BODY;
                res.body_byte = in_byte;
                rem_next      = rem_dec;
                if (rem_dec == '0) begin
                    res.last = 1'b1;
                    restart  = 1'b1;
                end
            end
            PH_SKIP: begin
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    restart = 1'b1;
                end
            end
            default: begin
                term_cnt_next = term_new[1:0];
                if (in_byte == CH_LF) begin
                    // Close the line; the first tagged line fixes the length.
                    if (vs_reg != VS_NONE && !seen_reg) begin
                        if (vs_reg != VS_DIGITS && vs_reg != VS_TRAIL) begin
                            len_v = '0;
                        end
                        seen_v = 1'b1;
                    end
                    tag_idx_next = '0;
                    vs_next      = VS_NONE;
                    acc_next     = len_v;
                    seen_next    = seen_v;
                    if (term_new == TERM_LEN) begin
                        restart   = 1'b1;
                        res.last  = 1'b1;
                        res_valid = 1'b1;
                        if (!seen_v) begin
                            res.kind = KIND_MISSING;
                        end else if (CW'(len_v) > CW'(max_len_reg)) begin
                            res.kind = KIND_OVER;
                            if (!len_v[LENGTH_BITS]) begin
                                load_phase = PH_SKIP;
                                load_rem   = len_v[LENGTH_BITS-1:0];
                            end
                        end else if (len_v == '0) begin
                            res.kind = KIND_EMPTY;
                        end else begin
                            res_valid  = 1'b0;
                            load_phase = PH_BODY;
                            load_rem   = len_v[LENGTH_BITS-1:0];
                        end
                    end
                end else if (vs_reg != VS_NONE) begin
                    unique case (vs_reg)
                        VS_LEAD: begin
                            if (is_digit) begin
                                acc_next = acc_first;
                                vs_next  = VS_DIGITS;
                            end else if (in_byte == CH_PLUS) begin
                                vs_next = VS_SIGN;
                            end else if (!is_space) begin
                                vs_next = VS_BAD;
                            end
                        end
                        VS_SIGN: begin
                            if (is_digit) begin
                                acc_next = acc_first;
                                vs_next  = VS_DIGITS;
                            end else begin
                                vs_next = VS_BAD;
                            end
                        end
                        VS_DIGITS: begin
                            if (is_digit) begin
                                acc_next = acc_digit;
                            end else if (is_space) begin
                                vs_next = VS_TRAIL;
                            end else begin
                                vs_next = VS_BAD;
                            end
                        end
                        VS_TRAIL: begin
                            if (!is_space) begin
                                vs_next = VS_BAD;
                            end
                        end
                        default: begin
                            vs_next = VS_BAD;
                        end
                    endcase
                end else if (tag_idx_reg < TAG_LEN) begin
                    if (in_byte == tag_char(tag_idx_reg)) begin
                        tag_idx_next = tag_idx_reg + 4'd1;
                        if (tag_idx_reg == TAG_LAST && !seen_reg) begin
                            vs_next  = VS_LEAD;
                            acc_next = '0;
                        end
                    end else begin
                        tag_idx_next = TAG_LEN;
                    end
                end
            end
        endcase

        if (restart) begin
            phase_next    = load_phase;
            tag_idx_next  = '0;
            term_cnt_next = '0;
            vs_next       = VS_NONE;
            acc_next      = '0;
            seen_next     = 1'b0;
            rem_next      = load_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            tag_idx_reg  <= '0;
            term_cnt_reg <= '0;
            vs_reg       <= VS_NONE;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            rem_reg      <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            tag_idx_reg  <= tag_idx_next;
            term_cnt_reg <= term_cnt_next;
            vs_reg       <= vs_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
            rem_reg      <= rem_next;
        end
    end

endmodule

// ===== src/clmd_output_stage.sv =====
module clmd_output_stage
    import clmd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  clmd_result_t res,
    output logic         free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic         valid_reg;
    clmd_result_t res_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.body_byte;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== src/content_length_message_deframer_top.sv =====
// Path: a word accepted into the input register is parsed when it advances; its result word,
// if any, is loaded into the output register at that same edge and is then driven on m_*.
// Throughput: one input word per cycle while the result register is free (m_tready stalls it).
// Reset: aresetn is synchronous, active low; it empties both stages, returns the parser to
// the start of a header line and sets max_body_length to its largest value.
module content_length_message_deframer_top
    import clmd_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: max_body_length
    input  logic                 cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] cfg_wr_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] body_byte
    output logic [1:0]           m_tuser,   // [1:0] kind
    output logic                 m_tlast    // last_of_message
);

    logic         in_valid;
    logic [7:0]   in_byte;
    logic         out_free;
    logic         advance;
    logic         res_valid;
    clmd_result_t res;

    // Advance the parser whenever a word is held and the result register can take
    // whatever it produces; words that produce nothing still need the slot free,
    // which keeps the control simple and costs nothing at full rate.
    assign advance = in_valid && out_free;

    // Hold the accepted byte in a register so the parser sees a registered input.
    clmd_input_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    // Header tag match, terminator search, length parse and body count.
    clmd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .in_byte     (in_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register: decouples the parser from a stalled downstream.
    clmd_output_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
